// File: rtl/core/cln_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cln_pkg
// Types and codes shared by the cell list neighbor search block.
// ----------------------------------------------------------------------------
package cln_pkg;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	localparam logic [1:0] KIND_CLEAR    = 2'd0;
	localparam logic [1:0] KIND_INSERT   = 2'd1;
	localparam logic [1:0] KIND_NEIGHBOR = 2'd2;
	localparam logic [1:0] KIND_SUMMARY  = 2'd3;

	localparam logic [1:0] ST_BINNED  = 2'd0;
	localparam logic [1:0] ST_OUTSIDE = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_INV_CELL = 3'd2;
	localparam logic [2:0] REG_COLUMNS  = 3'd3;
	localparam logic [2:0] REG_ROWS     = 3'd4;
	localparam logic [2:0] REG_RADIUS   = 3'd5;

	localparam logic [6:0] OVF_MAX = 7'd127;

	typedef struct packed {
		logic [1:0]         command;
		logic [9:0]         particle_index;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} in_item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [1:0] status;
		logic [9:0] cell_number;
		logic [9:0] neighbor_index;
		logic [5:0] neighbor_total;
		logic [6:0] overflow_total;
		logic [6:0] overflow_peak;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic [31:0]        inverse_cell_size;
		logic [10:0]        grid_columns;
		logic [10:0]        grid_rows;
		logic [62:0]        radius_squared;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [9:0]         particle_index;
		logic               index_ok;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} job_t;

endpackage

// File: rtl/core/cln_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cln_front
// Accepts input transactions, decodes them and queues jobs for the engine.
// ----------------------------------------------------------------------------
module cln_front import cln_pkg::*; #(
	parameter int PARTICLE_SLOTS = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t in_item,
	input  logic     in_valid,
	output logic     in_stall,
	output job_t     job,
	output logic     job_valid,
	input  logic     job_pop
);

	job_t        ent_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic [16:0] idx_ext;
	job_t        new_job;

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall && (in_item.command != CMD_NONE);
	assign job       = ent_q[rd_q];
	assign job_valid = (cnt_q != 2'd0);
	assign idx_ext   = {7'b0, in_item.particle_index};

	always_comb begin
		new_job.command        = in_item.command;
		new_job.particle_index = in_item.particle_index;
		new_job.index_ok       = (idx_ext < 17'(PARTICLE_SLOTS));
		new_job.pos_x          = in_item.pos_x;
		new_job.pos_y          = in_item.pos_y;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= new_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (job_pop && job_valid) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(job_pop && job_valid);
		end
	end

endmodule

// File: rtl/core/cln_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cln_engine
// Sequencer that bins particles, sweeps cell counts and walks the 3x3 cells.
// ----------------------------------------------------------------------------
module cln_engine import cln_pkg::*; #(
	parameter int PARTICLE_SLOTS = 1024,
	parameter int CELL_SLOTS     = 1024,
	parameter int CELL_CAPACITY  = 8,
	parameter int NEIGHBOR_LIMIT = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  job_t      job,
	input  logic      job_valid,
	output logic      job_pop,
	output out_item_t out_item,
	output logic      out_valid,
	input  logic      out_stall
);

	localparam int PW     = $clog2(PARTICLE_SLOTS);
	localparam int CW     = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;
	localparam int FW     = $clog2(CELL_CAPACITY + 1);
	localparam int MDEPTH = CELL_SLOTS * CELL_CAPACITY;
	localparam int MW     = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
	localparam int NW     = $clog2(NEIGHBOR_LIMIT + 1);

	localparam logic [CW-1:0] CLR_LAST = CW'(CELL_SLOTS - 1);
	localparam logic [FW-1:0] CAPF     = FW'(CELL_CAPACITY);
	localparam logic [MW-1:0] CAPM     = MW'(CELL_CAPACITY);
	localparam logic [NW-1:0] NLIM     = NW'(NEIGHBOR_LIMIT);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_CLR     = 5'd1;
	localparam logic [4:0] S_CDONE   = 5'd2;
	localparam logic [4:0] S_BAD     = 5'd3;
	localparam logic [4:0] S_QRD     = 5'd4;
	localparam logic [4:0] S_QGET    = 5'd5;
	localparam logic [4:0] S_COORD_A = 5'd6;
	localparam logic [4:0] S_COORD_B = 5'd7;
	localparam logic [4:0] S_COORD_C = 5'd8;
	localparam logic [4:0] S_CELL_A  = 5'd9;
	localparam logic [4:0] S_CELL_B  = 5'd10;
	localparam logic [4:0] S_CELL_C  = 5'd11;
	localparam logic [4:0] S_MEM_A   = 5'd12;
	localparam logic [4:0] S_MEM_B   = 5'd13;
	localparam logic [4:0] S_MEM_C   = 5'd14;
	localparam logic [4:0] S_MEM_D   = 5'd15;
	localparam logic [4:0] S_MEM_E   = 5'd16;
	localparam logic [4:0] S_NEXT    = 5'd17;
	localparam logic [4:0] S_SUMM    = 5'd18;

	logic signed [31:0] sx_mem [PARTICLE_SLOTS];
	logic signed [31:0] sy_mem [PARTICLE_SLOTS];
	logic [FW-1:0]      fill_mem [CELL_SLOTS];
	logic [9:0]         mbr_mem [MDEPTH];

	logic signed [31:0] sx_rd, sy_rd;
	logic [FW-1:0]      fill_rd;
	logic [9:0]         mbr_rd;

	logic [4:0]         st_q;
	logic [CW-1:0]      clr_q;
	logic               clr_emit_q;
	logic [6:0]         peak_q;
	logic               out_valid_q;
	out_item_t          out_q;
	logic [1:0]         cmd_q;
	logic [9:0]         idx_q;
	logic signed [31:0] px_q, py_q;
	logic [31:0]        magx_q, magy_q;
	logic               negx_q, negy_q;
	logic [63:0]        prodx_q, prody_q;
	logic [33:0]        cx_q, cy_q;
	logic [1:0]         ox_q, oy_q;
	logic               inr_q;
	logic [10:0]        ncx_lo_q;
	logic [21:0]        rowp_q;
	logic [21:0]        c_q;
	logic               cok_q;
	logic [FW-1:0]      kcnt_q, fcnt_q;
	logic [63:0]        sqx_q, sqy_q;
	logic [NW-1:0]      n_q;
	logic [6:0]         ovf_q;

	logic               slot;
	logic [32:0]        dx, dy, ex, ey;
	logic [34:0]        ncx, ncy;
	logic [21:0]        c_now;
	logic [64:0]        dsum;
	logic               inrad;
	logic [16:0]        idx_ext, j_ext;
	logic [PW-1:0]      sxy_ra;
	logic               sxy_we;
	logic [PW-1:0]      sxy_wa;
	logic [MW-1:0]      mbase;
	logic               ins_ok;
	logic               fill_we;
	logic [CW-1:0]      fill_wa, fill_ra;
	logic [FW-1:0]      fill_wd;
	logic               k_more;
	logic [6:0]         peak_new;
	logic               emit;
	out_item_t          emit_item;

	assign slot      = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign job_pop   = (st_q == S_IDLE) && job_valid;

	assign dx = {px_q[31], px_q} - {cfg.origin_x[31], cfg.origin_x};
	assign dy = {py_q[31], py_q} - {cfg.origin_y[31], cfg.origin_y};
	assign ex = {sx_rd[31], sx_rd} - {px_q[31], px_q};
	assign ey = {sy_rd[31], sy_rd} - {py_q[31], py_q};

	assign ncx   = {cx_q[33], cx_q} + {33'b0, ox_q} - 35'd1;
	assign ncy   = {cy_q[33], cy_q} + {33'b0, oy_q} - 35'd1;
	assign c_now = 22'(ncx_lo_q) + rowp_q;

	assign dsum  = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign inrad = !dsum[64] && (dsum[63:0] < {1'b0, cfg.radius_squared});

	assign idx_ext = {7'b0, idx_q};
	assign j_ext   = {7'b0, mbr_rd};
	assign sxy_ra  = (st_q == S_MEM_B) ? j_ext[PW-1:0] : idx_ext[PW-1:0];

	assign sxy_we = job_pop && (job.command == CMD_INSERT) && job.index_ok;
	always_comb begin
		logic [16:0] wi;
		wi     = {7'b0, job.particle_index};
		sxy_wa = wi[PW-1:0];
	end

	assign mbase   = MW'(c_q[CW-1:0]) * CAPM;
	assign ins_ok  = (st_q == S_CELL_C) && (cmd_q == CMD_INSERT) && cok_q
		&& (fill_rd < CAPF) && slot;
	assign fill_we = (st_q == S_CLR) || ins_ok;
	assign fill_wa = (st_q == S_CLR) ? clr_q : c_q[CW-1:0];
	assign fill_wd = (st_q == S_CLR) ? '0 : fill_rd + FW'(1);
	assign fill_ra = (st_q == S_CELL_B) ? c_now[CW-1:0] : c_q[CW-1:0];
	assign k_more  = ({1'b0, kcnt_q} + {{FW{1'b0}}, 1'b1}) < {1'b0, fcnt_q};
	assign peak_new = (ovf_q > peak_q) ? ovf_q : peak_q;

	// result transaction built for the current state
	always_comb begin
		emit      = 1'b0;
		emit_item = '0;
		emit_item.last = 1'b1;
		case (st_q)
			S_CDONE: begin
				emit = slot;
				emit_item.result_kind = KIND_CLEAR;
			end
			S_BAD: begin
				emit = slot;
				if (cmd_q == CMD_INSERT) begin
					emit_item.result_kind = KIND_INSERT;
					emit_item.status      = ST_OUTSIDE;
				end else begin
					emit_item.result_kind   = KIND_SUMMARY;
					emit_item.overflow_peak = peak_q;
				end
			end
			S_CELL_C: begin
				emit = slot && (cmd_q == CMD_INSERT);
				emit_item.result_kind = KIND_INSERT;
				if (!cok_q) begin
					emit_item.status = ST_OUTSIDE;
				end else if (fill_rd >= CAPF) begin
					emit_item.status = ST_FULL;
				end else begin
					emit_item.status      = ST_BINNED;
					emit_item.cell_number = c_q[9:0];
				end
			end
			S_MEM_E: begin
				emit = slot && inrad && (n_q < NLIM);
				emit_item.result_kind    = KIND_NEIGHBOR;
				emit_item.neighbor_index = mbr_rd;
				emit_item.last           = 1'b0;
			end
			S_SUMM: begin
				emit = slot;
				emit_item.result_kind    = KIND_SUMMARY;
				emit_item.neighbor_total = 6'(n_q);
				emit_item.overflow_total = ovf_q;
				emit_item.overflow_peak  = peak_new;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (sxy_we) begin
			sx_mem[sxy_wa] <= job.pos_x;
			sy_mem[sxy_wa] <= job.pos_y;
		end
		sx_rd <= sx_mem[sxy_ra];
		sy_rd <= sy_mem[sxy_ra];
	end

	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_wa] <= fill_wd;
		end
		fill_rd <= fill_mem[fill_ra];
	end

	always_ff @(posedge clk) begin
		if (ins_ok) begin
			mbr_mem[mbase + MW'(fill_rd)] <= idx_q;
		end
		mbr_rd <= mbr_mem[mbase + MW'(kcnt_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLR;
			clr_q       <= '0;
			clr_emit_q  <= 1'b0;
			peak_q      <= 7'd0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && out_stall);
			if (emit) begin
				out_q <= emit_item;
			end
			case (st_q)
				S_IDLE: begin
					if (job_valid) begin
						cmd_q <= job.command;
						idx_q <= job.particle_index;
						px_q  <= job.pos_x;
						py_q  <= job.pos_y;
						n_q   <= '0;
						ovf_q <= 7'd0;
						if (job.command == CMD_CLEAR) begin
							clr_q      <= '0;
							clr_emit_q <= 1'b1;
							peak_q     <= 7'd0;
							st_q       <= S_CLR;
						end else if (!job.index_ok) begin
							st_q <= S_BAD;
						end else if (job.command == CMD_INSERT) begin
							ox_q <= 2'd1;
							oy_q <= 2'd1;
							st_q <= S_COORD_A;
						end else begin
							ox_q <= 2'd0;
							oy_q <= 2'd0;
							st_q <= S_QRD;
						end
					end
				end
				S_CLR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CLR_LAST) begin
						st_q <= clr_emit_q ? S_CDONE : S_IDLE;
					end
				end
				S_CDONE: begin
					if (slot) begin
						st_q <= S_IDLE;
					end
				end
				S_BAD: begin
					if (slot) begin
						st_q <= S_IDLE;
					end
				end
				S_QRD: begin
					st_q <= S_QGET;
				end
				S_QGET: begin
					px_q <= sx_rd;
					py_q <= sy_rd;
					st_q <= S_COORD_A;
				end
				S_COORD_A: begin
					negx_q <= dx[32];
					negy_q <= dy[32];
					magx_q <= dx[32] ? 32'(-dx) : dx[31:0];
					magy_q <= dy[32] ? 32'(-dy) : dy[31:0];
					st_q   <= S_COORD_B;
				end
				S_COORD_B: begin
					prodx_q <= 64'(magx_q) * 64'(cfg.inverse_cell_size);
					prody_q <= 64'(magy_q) * 64'(cfg.inverse_cell_size);
					st_q    <= S_COORD_C;
				end
				S_COORD_C: begin
					cx_q <= negx_q ? (34'd0 - {2'b0, prodx_q[63:32]} - 34'(|prodx_q[31:0]))
						: {2'b0, prodx_q[63:32]};
					cy_q <= negy_q ? (34'd0 - {2'b0, prody_q[63:32]} - 34'(|prody_q[31:0]))
						: {2'b0, prody_q[63:32]};
					st_q <= S_CELL_A;
				end
				S_CELL_A: begin
					inr_q    <= !ncx[34] && !ncy[34] && (ncx < 35'(cfg.grid_columns))
						&& (ncy < 35'(cfg.grid_rows));
					ncx_lo_q <= ncx[10:0];
					rowp_q   <= 22'(ncy[10:0]) * 22'(cfg.grid_columns);
					st_q     <= S_CELL_B;
				end
				S_CELL_B: begin
					c_q   <= c_now;
					cok_q <= inr_q && (c_now < 22'(CELL_SLOTS));
					st_q  <= S_CELL_C;
				end
				S_CELL_C: begin
					if (cmd_q == CMD_INSERT) begin
						if (slot) begin
							st_q <= S_IDLE;
						end
					end else begin
						kcnt_q <= '0;
						fcnt_q <= fill_rd;
						st_q   <= (cok_q && fill_rd != '0) ? S_MEM_A : S_NEXT;
					end
				end
				S_MEM_A: begin
					st_q <= S_MEM_B;
				end
				S_MEM_B: begin
					if (mbr_rd == idx_q || j_ext >= 17'(PARTICLE_SLOTS)) begin
						kcnt_q <= kcnt_q + FW'(1);
						st_q   <= k_more ? S_MEM_A : S_NEXT;
					end else begin
						st_q <= S_MEM_C;
					end
				end
				S_MEM_C: begin
					magx_q <= ex[32] ? 32'(-ex) : ex[31:0];
					magy_q <= ey[32] ? 32'(-ey) : ey[31:0];
					st_q   <= S_MEM_D;
				end
				S_MEM_D: begin
					sqx_q <= 64'(magx_q) * 64'(magx_q);
					sqy_q <= 64'(magy_q) * 64'(magy_q);
					st_q  <= S_MEM_E;
				end
				S_MEM_E: begin
					if (inrad && n_q < NLIM) begin
						if (slot) begin
							n_q    <= n_q + NW'(1);
							kcnt_q <= kcnt_q + FW'(1);
							st_q   <= k_more ? S_MEM_A : S_NEXT;
						end
					end else begin
						if (inrad && ovf_q < OVF_MAX) begin
							ovf_q <= ovf_q + 7'd1;
						end
						kcnt_q <= kcnt_q + FW'(1);
						st_q   <= k_more ? S_MEM_A : S_NEXT;
					end
				end
				S_NEXT: begin
					if (ox_q == 2'd2) begin
						ox_q <= 2'd0;
						if (oy_q == 2'd2) begin
							st_q <= S_SUMM;
						end else begin
							oy_q <= oy_q + 2'd1;
							st_q <= S_CELL_A;
						end
					end else begin
						ox_q <= ox_q + 2'd1;
						st_q <= S_CELL_A;
					end
				end
				S_SUMM: begin
					if (slot) begin
						peak_q <= peak_new;
						st_q   <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/cell_list_neighbor_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_list_neighbor_search
// 2D uniform grid binning and 3x3 neighbor search over stored particles.
// ----------------------------------------------------------------------------
// Input channel in_item/in_valid/in_stall carries clear, insert and query
// commands; a transaction completes when in_valid is high and in_stall low.
// Output channel out_item/out_valid/out_stall returns one transaction per
// result; last marks the final result of a command. Command 3 returns nothing.
// Configuration writes arrive on cfg_valid/cfg_ready/cfg_index/cfg_data and
// are taken every cycle; write them only while the block is idle.
// A two-entry job queue sits in front of the engine, so commands are taken
// while the engine works or the output is stalled.
// A query scans the members of up to nine cells, skipping the queried
// particle's own entries, and its neighbors leave as they are found. The
// engine takes the next command the cycle after it registers the last
// result, so it works on one command at a time. After reset the engine
// sweeps every cell count to zero before it takes its first job. A
// stalled output holds the engine in place.
// ----------------------------------------------------------------------------
module cell_list_neighbor_search import cln_pkg::*; #(
	parameter int PARTICLE_SLOTS = 1024,
	parameter int CELL_SLOTS     = 1024,
	parameter int CELL_CAPACITY  = 8,
	parameter int NEIGHBOR_LIMIT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  in_item_t    in_item,
	input  logic        in_valid,
	output logic        in_stall,
	output out_item_t   out_item,
	output logic        out_valid,
	input  logic        out_stall,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	cfg_t cfg_q;
	job_t job;
	logic job_valid;
	logic job_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x          <= 32'sd0;
			cfg_q.origin_y          <= 32'sd0;
			cfg_q.inverse_cell_size <= 32'd65536;
			cfg_q.grid_columns      <= 11'd32;
			cfg_q.grid_rows         <= 11'd32;
			cfg_q.radius_squared    <= 63'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ORIGIN_X: cfg_q.origin_x          <= cfg_data[31:0];
				REG_ORIGIN_Y: cfg_q.origin_y          <= cfg_data[31:0];
				REG_INV_CELL: cfg_q.inverse_cell_size <= cfg_data[31:0];
				REG_COLUMNS:  cfg_q.grid_columns      <= cfg_data[10:0];
				REG_ROWS:     cfg_q.grid_rows         <= cfg_data[10:0];
				REG_RADIUS:   cfg_q.radius_squared    <= cfg_data[62:0];
				default: begin
				end
			endcase
		end
	end

	cln_front #(
		.PARTICLE_SLOTS(PARTICLE_SLOTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.job      (job),
		.job_valid(job_valid),
		.job_pop  (job_pop)
	);

	cln_engine #(
		.PARTICLE_SLOTS(PARTICLE_SLOTS),
		.CELL_SLOTS    (CELL_SLOTS),
		.CELL_CAPACITY (CELL_CAPACITY),
		.NEIGHBOR_LIMIT(NEIGHBOR_LIMIT)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.job      (job),
		.job_valid(job_valid),
		.job_pop  (job_pop),
		.out_item (out_item),
		.out_valid(out_valid),
		.out_stall(out_stall)
	);

endmodule

// File: verif/cell_list_neighbor_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_list_neighbor_search_tb
// Self-checking bench for the grid binning and neighbor search block.
// A directed table covers field extremes, every command, full cells, outside
// positions and the ignored command. Random phases follow, each under its
// own grid setup, with biased insert/query traffic and random handshake
// gaps. Each result is checked against a behavioral grid model or a table value.
// ----------------------------------------------------------------------------
module cell_list_neighbor_search_tb;
	import cln_pkg::*;

	localparam int SLOTS     = 1024;
	localparam int CAPACITY  = 8;
	localparam int NBR_LIMIT = 32;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		logic [1:0]  cmd;
		logic [9:0]  idx;
		logic [31:0] x;
		logic [31:0] y;
		bit          typed;
		out_item_t   want;
	} stim_row_t;

	localparam out_item_t CLEAR_DONE = '{KIND_CLEAR, ST_BINNED, 10'd0, 10'd0, 6'd0, 7'd0,
		7'd0, 1'b1};
	localparam out_item_t INS_OUTSIDE = '{KIND_INSERT, ST_OUTSIDE, 10'd0, 10'd0, 6'd0, 7'd0,
		7'd0, 1'b1};
	localparam out_item_t INS_FULL = '{KIND_INSERT, ST_FULL, 10'd0, 10'd0, 6'd0, 7'd0,
		7'd0, 1'b1};
	localparam out_item_t NONE = '0;

	logic        clk;
	logic        arst_n;
	in_item_t    in_item;
	logic        in_valid;
	logic        in_stall;
	out_item_t   out_item;
	logic        out_valid;
	logic        out_stall;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	cell_list_neighbor_search dut (
		.clk(clk), .arst_n(arst_n),
		.in_item(in_item), .in_valid(in_valid), .in_stall(in_stall),
		.out_item(out_item), .out_valid(out_valid), .out_stall(out_stall),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// grid model
	longint          org_x, org_y;
	longint unsigned inv_cs, cols, rows, rad;
	longint          pos_x_mem [SLOTS];
	longint          pos_y_mem [SLOTS];
	int              fill [SLOTS];
	int              members [SLOTS][CAPACITY];
	int              peak_ovf;
	bit              was_inserted [SLOTS];
	int              inserted_ids [$];

	out_item_t pending_results [$];
	int        errors;
	int        send_gap_pct;
	int        stall_pct;
	int        idle_cycles;

	stim_row_t directed_rows [20] = '{
		'{CMD_CLEAR,  10'd0,    32'h0,        32'h0,        1'b1, CLEAR_DONE},
		'{CMD_INSERT, 10'd0,    32'h0,        32'h0,        1'b0, NONE},
		'{CMD_INSERT, 10'd1023, 32'h0001_8000, 32'h0000_8000, 1'b0, NONE},
		'{CMD_INSERT, 10'd5,    32'h7FFF_FFFF, 32'h0000_0000, 1'b1, INS_OUTSIDE},
		'{CMD_INSERT, 10'd6,    32'h8000_0000, 32'hFFFF_FFFF, 1'b1, INS_OUTSIDE},
		'{CMD_INSERT, 10'd7,    32'h001F_8000, 32'h001F_8000, 1'b0, NONE},
		'{CMD_INSERT, 10'd10,   32'h0000_4000, 32'h0000_4000, 1'b0, NONE},
		'{CMD_INSERT, 10'd11,   32'h0000_4000, 32'h0000_4000, 1'b0, NONE},
		'{CMD_INSERT, 10'd12,   32'h0000_4000, 32'h0000_8000, 1'b0, NONE},
		'{CMD_INSERT, 10'd13,   32'h0000_8000, 32'h0000_4000, 1'b0, NONE},
		'{CMD_INSERT, 10'd14,   32'h0000_C000, 32'h0000_C000, 1'b0, NONE},
		'{CMD_INSERT, 10'd15,   32'h0000_FFFF, 32'h0000_FFFF, 1'b0, NONE},
		'{CMD_INSERT, 10'd16,   32'h0000_0001, 32'h0000_0001, 1'b0, NONE},
		'{CMD_INSERT, 10'd17,   32'h0000_2000, 32'h0000_2000, 1'b1, INS_FULL},
		'{CMD_QUERY,  10'd0,    32'h0,        32'h0,        1'b0, NONE},
		'{CMD_QUERY,  10'd5,    32'h0,        32'h0,        1'b0, NONE},
		'{CMD_NONE,   10'd0,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NONE},
		'{CMD_QUERY,  10'd7,    32'h0,        32'h0,        1'b0, NONE},
		'{CMD_CLEAR,  10'd1023, 32'h0,        32'h0,        1'b1, CLEAR_DONE},
		'{CMD_QUERY,  10'd1023, 32'h0,        32'h0,        1'b0, NONE}
	};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint cell_coord(longint p, longint org);
		longint          d;
		longint unsigned mag;
		longint unsigned prod;
		d = p - org;
		mag = (d < 0) ? longint'(-d) : longint'(d);
		prod = mag * inv_cs;
		if (d < 0)
			return -longint'(prod >> 32) - ((prod[31:0] != 0) ? 1 : 0);
		return longint'(prod >> 32);
	endfunction

	function automatic bit cell_at(longint cx, longint cy, output int c);
		longint lc;
		c = 0;
		if (cx < 0 || cy < 0 || cx >= longint'(cols) || cy >= longint'(rows))
			return 1'b0;
		lc = cx + cy * longint'(cols);
		if (lc >= SLOTS)
			return 1'b0;
		c = int'(lc);
		return 1'b1;
	endfunction

	function automatic longint unsigned sq_sat(longint d);
		longint unsigned m;
		m = (d < 0) ? longint'(-d) : longint'(d);
		if (m > 64'hFFFF_FFFF)
			return '1;
		return m * m;
	endfunction

	task automatic bin_and_search(input in_item_t it, output out_item_t res [$]);
		out_item_t        r;
		int               c, n, ovf, j, p;
		longint           cx, cy, xi, yi;
		longint unsigned  a, b;
		logic [64:0]      s;
		longint unsigned  d2;
		res = {};
		r = '0;
		r.last = 1'b1;
		p = it.particle_index;
		case (it.command)
			CMD_CLEAR: begin
				foreach (fill[i]) fill[i] = 0;
				peak_ovf = 0;
				r.result_kind = KIND_CLEAR;
				res.push_back(r);
			end
			CMD_INSERT: begin
				pos_x_mem[p] = longint'($signed(it.pos_x));
				pos_y_mem[p] = longint'($signed(it.pos_y));
				if (!was_inserted[p]) begin
					was_inserted[p] = 1'b1;
					inserted_ids.push_back(p);
				end
				r.result_kind = KIND_INSERT;
				if (!cell_at(cell_coord(pos_x_mem[p], org_x), cell_coord(pos_y_mem[p], org_y), c))
					r.status = ST_OUTSIDE;
				else if (fill[c] >= CAPACITY)
					r.status = ST_FULL;
				else begin
					members[c][fill[c]] = p;
					fill[c]++;
					r.status = ST_BINNED;
					r.cell_number = c[9:0];
				end
				res.push_back(r);
			end
			CMD_QUERY: begin
				n = 0;
				ovf = 0;
				xi = pos_x_mem[p];
				yi = pos_y_mem[p];
				cx = cell_coord(xi, org_x);
				cy = cell_coord(yi, org_y);
				for (int oy = -1; oy <= 1; oy++)
					for (int ox = -1; ox <= 1; ox++) begin
						if (!cell_at(cx + ox, cy + oy, c))
							continue;
						for (int k = 0; k < fill[c]; k++) begin
							j = members[c][k];
							if (j == p)
								continue;
							a = sq_sat(pos_x_mem[j] - xi);
							b = sq_sat(pos_y_mem[j] - yi);
							s = {1'b0, a} + {1'b0, b};
							d2 = s[64] ? '1 : s[63:0];
							if (d2 < rad) begin
								if (n < NBR_LIMIT) begin
									out_item_t nb;
									nb = '0;
									nb.result_kind = KIND_NEIGHBOR;
									nb.neighbor_index = j[9:0];
									res.push_back(nb);
									n++;
								end else if (ovf < OVF_MAX)
									ovf++;
							end
						end
					end
				if (ovf > peak_ovf)
					peak_ovf = ovf;
				r.result_kind = KIND_SUMMARY;
				r.neighbor_total = n[5:0];
				r.overflow_total = ovf[6:0];
				r.overflow_peak = peak_ovf[6:0];
				res.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic cmp_field(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task automatic send(input in_item_t it, input bit typed, input out_item_t want);
		out_item_t res [$];
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_item = it;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		bin_and_search(it, res);
		if (typed)
			pending_results.push_back(want);
		else
			foreach (res[i]) pending_results.push_back(res[i]);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ORIGIN_X: org_x = longint'($signed(val[31:0]));
			REG_ORIGIN_Y: org_y = longint'($signed(val[31:0]));
			REG_INV_CELL: inv_cs = val[31:0];
			REG_COLUMNS:  cols = val[10:0];
			REG_ROWS:     rows = val[10:0];
			REG_RADIUS:   rad = val[62:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic setup_grid(input cfg_t c);
		write_reg(REG_ORIGIN_X, {32'h0, c.origin_x});
		write_reg(REG_ORIGIN_Y, {32'h0, c.origin_y});
		write_reg(REG_INV_CELL, {32'h0, c.inverse_cell_size});
		write_reg(REG_COLUMNS, {53'h0, c.grid_columns});
		write_reg(REG_ROWS, {53'h0, c.grid_rows});
		write_reg(REG_RADIUS, {1'b0, c.radius_squared});
	endtask

	task automatic set_idle(input int mode);
		case (mode % 4)
			0: begin send_gap_pct = 0;  stall_pct = 0;  end
			1: begin send_gap_pct = 47; stall_pct = 0;  end
			2: begin send_gap_pct = 0;  stall_pct = 47; end
			default: begin send_gap_pct = 16; stall_pct = 16; end
		endcase
	endtask

	task automatic random_phase(input int mode, input cfg_t c, input int span_x,
		input int span_y, input int count);
		in_item_t it;
		int       roll;
		drain();
		setup_grid(c);
		set_idle(mode);
		for (int i = 0; i < count; i++) begin
			it = '0;
			roll = $urandom_range(99);
			it.particle_index = $urandom_range(SLOTS - 1);
			if (roll < 3)
				it.command = CMD_CLEAR;
			else if (roll < 6) begin
				it.command = CMD_NONE;
				it.pos_x = $urandom;
				it.pos_y = $urandom;
			end else if (roll < 50 || inserted_ids.size() == 0) begin
				it.command = CMD_INSERT;
				if ($urandom_range(9) == 0) begin
					it.pos_x = $urandom;
					it.pos_y = $urandom;
				end else begin
					it.pos_x = c.origin_x + $urandom_range(span_x);
					it.pos_y = c.origin_y + $urandom_range(span_y);
				end
			end else begin
				it.command = CMD_QUERY;
				it.particle_index = inserted_ids[$urandom_range(inserted_ids.size() - 1)];
				it.pos_x = $urandom;
				it.pos_y = $urandom;
			end
			send(it, 1'b0, NONE);
		end
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0)
				report("result with nothing expected");
			else begin
				out_item_t w;
				w = pending_results.pop_front();
				cmp_field("result_kind", out_item.result_kind, w.result_kind);
				cmp_field("status", out_item.status, w.status);
				cmp_field("cell_number", out_item.cell_number, w.cell_number);
				cmp_field("neighbor_index", out_item.neighbor_index, w.neighbor_index);
				cmp_field("neighbor_total", out_item.neighbor_total, w.neighbor_total);
				cmp_field("overflow_total", out_item.overflow_total, w.overflow_total);
				cmp_field("overflow_peak", out_item.overflow_peak, w.overflow_peak);
				cmp_field("last", out_item.last, w.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		in_item_t it;
		errors = 0;
		idle_cycles = 0;
		send_gap_pct = 0;
		stall_pct = 0;
		in_item = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_ORIGIN_X;
		cfg_data = '0;
		org_x = 0;
		org_y = 0;
		inv_cs = 64'd65536;
		cols = 32;
		rows = 32;
		rad = 0;
		peak_ovf = 0;
		foreach (fill[i]) begin
			fill[i] = 0;
			pos_x_mem[i] = 0;
			pos_y_mem[i] = 0;
			was_inserted[i] = 1'b0;
		end
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		setup_grid('{32'sh0, 32'sh0, 32'h0001_0000, 11'd32, 11'd32, 63'h4_0000_0000});
		foreach (directed_rows[i]) begin
			it.command = directed_rows[i].cmd;
			it.particle_index = directed_rows[i].idx;
			it.pos_x = directed_rows[i].x;
			it.pos_y = directed_rows[i].y;
			send(it, directed_rows[i].typed, directed_rows[i].want);
		end

		random_phase(1, '{32'sh8000_0000, -32'sh10_0000, 32'h0004_0000, 11'd1024, 11'd1,
			63'h4000_0000}, 32'h0100_0000, 32'h0000_4000, 50);
		random_phase(2, '{32'sh1_0000, 32'sh1_0000, 32'h0000_8000, 11'd4, 11'd4,
			63'h7FFF_FFFF_FFFF_FFFF}, 32'h0008_0000, 32'h0008_0000, 60);
		random_phase(3, '{32'sh7FFF_FFFF, 32'sh0, 32'h0, 11'd1, 11'd1, 63'h0},
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 30);
		random_phase(0, '{32'sh0, 32'sh8000_0000, 32'hFFFF_FFFF, 11'd0, 11'd0,
			63'h100_0000_0000}, 32'h0000_FFFF, 32'h0000_FFFF, 20);
		random_phase(1, '{32'sh0, 32'sh0, 32'h0001_0000, 11'd33, 11'd1024,
			63'h9_0000_0000}, 32'h0021_0000, 32'h0028_0000, 50);

		drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
